// ===== sv/cbcz_pkg.sv =====
// package for the color blob centroid zone block
// holds payload structs, config layout, register codes, zone codes and back-end states
// no dependencies
`default_nettype none

package cbcz_pkg;

  localparam int CENT_W  = 10;
  localparam int COUNT_W = 21;
  localparam int CH_W    = 8;
  localparam int SIDE_W  = 11;
  localparam int IDX_W   = 3;

  typedef struct packed {
    logic [CH_W-1:0] hue;
    logic [CH_W-1:0] sat;
    logic [CH_W-1:0] val;
  } pixel_t;

  typedef enum logic [1:0] {
    ZONE_NONE   = 2'd0,
    ZONE_LEFT   = 2'd1,
    ZONE_CENTER = 2'd2,
    ZONE_RIGHT  = 2'd3
  } zone_t;

  typedef struct packed {
    logic               found;
    logic [CENT_W-1:0]  centroid_row;
    logic [CENT_W-1:0]  centroid_col;
    zone_t              zone;
    logic [COUNT_W-1:0] match_count;
  } result_t;

  typedef struct packed {
    logic [CH_W-1:0]   hue_min;
    logic [CH_W-1:0]   hue_max;
    logic [CH_W-1:0]   sat_min;
    logic [CH_W-1:0]   sat_max;
    logic [CH_W-1:0]   val_min;
    logic [CH_W-1:0]   val_max;
    logic [SIDE_W-1:0] frame_width;
    logic [SIDE_W-1:0] frame_height;
  } cfg_t;

  localparam logic [IDX_W-1:0] CFG_HUE_MIN      = 3'd0;
  localparam logic [IDX_W-1:0] CFG_HUE_MAX      = 3'd1;
  localparam logic [IDX_W-1:0] CFG_SAT_MIN      = 3'd2;
  localparam logic [IDX_W-1:0] CFG_SAT_MAX      = 3'd3;
  localparam logic [IDX_W-1:0] CFG_VAL_MIN      = 3'd4;
  localparam logic [IDX_W-1:0] CFG_VAL_MAX      = 3'd5;
  localparam logic [IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd6;
  localparam logic [IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd7;

  localparam cfg_t CFG_RESET = '{
    hue_min:      8'd120,
    hue_max:      8'd130,
    sat_min:      8'd0,
    sat_max:      8'd150,
    val_min:      8'd150,
    val_max:      8'd200,
    frame_width:  11'd160,
    frame_height: 11'd120
  };

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_CMP,
    BK_DIV,
    BK_DONE
  } back_state_t;

endpackage

`default_nettype wire

// ===== sv/cbcz_front.sv =====
// front end: pixel acceptance, color match, raster counters and per-frame sums
// depends on cbcz_pkg; pushes one frame record into the queue on the last pixel
`default_nettype none

module cbcz_front import cbcz_pkg::*; #(
  parameter int MAX_SIDE = 1024
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cfg_t                        cfg,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire pixel_t                      in_data,
  input  wire logic                        q_full,
  output logic                             push,
  output logic [$clog2(MAX_SIDE*MAX_SIDE+1)+$clog2(MAX_SIDE)-1:0] rsum_out,
  output logic [$clog2(MAX_SIDE*MAX_SIDE+1)+$clog2(MAX_SIDE)-1:0] csum_out,
  output logic [$clog2(MAX_SIDE*MAX_SIDE+1)-1:0]                  cnt_out,
  output logic [$clog2(MAX_SIDE+1)-1:0]    w_out,
  output logic [$clog2(MAX_SIDE+1)-1:0]    h_out
);

  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int CW   = $clog2(MAX_SIDE);
  localparam int NW   = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int SUMW = NW + CW;

  logic [CW-1:0]   col;
  logic [CW-1:0]   row;
  logic [NW-1:0]   cnt;
  logic [SUMW-1:0] rsum;
  logic [SUMW-1:0] csum;

  logic [SW-1:0]   w;
  logic [SW-1:0]   h;
  logic            accept;
  logic            match;
  logic            last_col;
  logic            last_row;
  logic [NW-1:0]   cnt_upd;
  logic [SUMW-1:0] rsum_upd;
  logic [SUMW-1:0] csum_upd;

  function automatic logic [SW-1:0] side_clamp(input logic [SIDE_W-1:0] v);
    logic [SW-1:0] r;
    if (v == '0) begin
      r = SW'(1);
    end else if (32'(v) > MAX_SIDE) begin
      r = SW'(MAX_SIDE);
    end else begin
      r = SW'(v);
    end
    return r;
  endfunction

  assign w = side_clamp(cfg.frame_width);
  assign h = side_clamp(cfg.frame_height);

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  assign match = (in_data.hue != '0) &&
                 (in_data.hue >= cfg.hue_min) && (in_data.hue <= cfg.hue_max) &&
                 (in_data.sat >= cfg.sat_min) && (in_data.sat <= cfg.sat_max) &&
                 (in_data.val >= cfg.val_min) && (in_data.val <= cfg.val_max);

  assign last_col = SW'(col) >= (w - SW'(1));
  assign last_row = SW'(row) >= (h - SW'(1));

  assign cnt_upd  = match ? cnt + NW'(1) : cnt;
  assign rsum_upd = match ? rsum + SUMW'(row) : rsum;
  assign csum_upd = match ? csum + SUMW'(col) : csum;

  assign push     = accept && last_col && last_row;
  assign cnt_out  = cnt_upd;
  assign rsum_out = rsum_upd;
  assign csum_out = csum_upd;
  assign w_out    = w;
  assign h_out    = h;

  always_ff @(posedge clk) begin
    if (rst) begin
      col  <= '0;
      row  <= '0;
      cnt  <= '0;
      rsum <= '0;
      csum <= '0;
    end else if (accept) begin
      if (!last_col) begin
        col  <= col + CW'(1);
        cnt  <= cnt_upd;
        rsum <= rsum_upd;
        csum <= csum_upd;
      end else if (!last_row) begin
        col  <= '0;
        row  <= row + CW'(1);
        cnt  <= cnt_upd;
        rsum <= rsum_upd;
        csum <= csum_upd;
      end else begin
        // frame done, totals leave through the queue
        col  <= '0;
        row  <= '0;
        cnt  <= '0;
        rsum <= '0;
        csum <= '0;
      end
    end
  end

  a_frame_clear: assert property (@(posedge clk) disable iff (rst)
    push |=> (col == '0) && (row == '0) && (cnt == '0) && (rsum == '0) && (csum == '0))
    else $error("front accumulators not cleared after frame end");

endmodule

`default_nettype wire

// ===== sv/cbcz_fifo.sv =====
// small register queue for frame records between front and back end
// generic width and depth, no package dependency
`default_nettype none

module cbcz_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] push_data,
  input  wire logic         pop,
  output logic [W-1:0]      pop_data,
  output logic              full,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int KW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [KW-1:0] fill;

  assign full     = (fill == KW'(DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        fill <= fill + KW'(1);
      end else if (pop && !push) begin
        fill <= fill - KW'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("frame queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("frame queue underflow");

endmodule

`default_nettype wire

// ===== sv/cbcz_div.sv =====
// restoring divider, one quotient bit per cycle
// quotient must fit in QW bits (upper dividend part below divisor); no package dependency
`default_nettype none

module cbcz_div #(
  parameter int DIVW = 21,
  parameter int QW   = 10
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [DIVW+QW-1:0]   dividend,
  input  wire logic [DIVW-1:0]      divisor,
  output logic                      busy,
  output logic [QW-1:0]             quotient
);

  localparam int KW = $clog2(QW + 1);

  logic [DIVW-1:0] rem;
  logic [QW-1:0]   low;
  logic [DIVW-1:0] dvs;
  logic [KW-1:0]   steps;

  logic [DIVW:0]   trial;
  logic [DIVW:0]   diff;
  logic            ge;

  assign trial = {rem, low[QW-1]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = trial >= {1'b0, dvs};
  assign busy  = (steps != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
    end else if (start) begin
      steps <= KW'(QW);
    end else if (busy) begin
      steps <= steps - KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend[DIVW+QW-1:QW];
      low      <= dividend[QW-1:0];
      dvs      <= divisor;
      quotient <= '0;
    end else if (busy) begin
      rem      <= ge ? diff[DIVW-1:0] : trial[DIVW-1:0];
      low      <= QW'({low, 1'b0});
      quotient <= QW'({quotient, ge});
    end
  end

endmodule

`default_nettype wire

// ===== sv/cbcz_back.sv =====
// back end: found test, centroid division, zone classification and result register
// depends on cbcz_pkg and cbcz_div; takes frame records from the queue
`default_nettype none

module cbcz_back import cbcz_pkg::*; #(
  parameter int MAX_SIDE = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  q_empty,
  output logic                                       pop,
  input  wire logic [2*($clog2(MAX_SIDE*MAX_SIDE+1)+$clog2(MAX_SIDE))
                     +$clog2(MAX_SIDE*MAX_SIDE+1)+2*$clog2(MAX_SIDE+1)-1:0] rec,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output result_t                                    out_data
);

  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int CW   = $clog2(MAX_SIDE);
  localparam int NW   = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int SUMW = NW + CW;
  localparam int AW   = NW + 9;
  localparam int ZW   = SW + 2;

  back_state_t state, state_next;

  logic [NW-1:0]   rec_cnt;
  logic [SUMW-1:0] rec_rsum;
  logic [SUMW-1:0] rec_csum;
  logic [SW-1:0]   rec_w;
  logic [SW-1:0]   rec_h;

  logic [NW-1:0]   cnt;
  logic [SUMW-1:0] rsum;
  logic [SUMW-1:0] csum;
  logic [SW-1:0]   w;
  logic [SW-1:0]   h;
  logic [AW-1:0]   area;
  logic [AW-1:0]   cnt400;
  logic            found;

  logic            div_start;
  logic            row_busy;
  logic            col_busy;
  logic [CW-1:0]   q_row;
  logic [CW-1:0]   q_col;

  logic            load;
  logic            do_latch;
  logic            do_mul;
  logic            do_cmp;
  logic            found_now;
  logic [ZW-1:0]   col4;
  logic [ZW-1:0]   w1;
  logic [ZW-1:0]   w3;
  zone_t           zone;

  assign {rec_cnt, rec_rsum, rec_csum, rec_w, rec_h} = rec;

  cbcz_div #(.DIVW(NW), .QW(CW)) u_div_row (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rsum),
    .divisor  (cnt),
    .busy     (row_busy),
    .quotient (q_row)
  );

  cbcz_div #(.DIVW(NW), .QW(CW)) u_div_col (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (csum),
    .divisor  (cnt),
    .busy     (col_busy),
    .quotient (q_col)
  );

  // 400 = 256 + 128 + 16
  assign found_now = cnt400 > area;

  always_comb begin
    col4 = ZW'({q_col, 2'b00});
    w1   = ZW'(w);
    w3   = w1 + (w1 << 1);
    if (!found) begin
      zone = ZONE_NONE;
    end else if ((q_col != '0) && (col4 < w1)) begin
      zone = ZONE_LEFT;
    end else if ((col4 >= w1) && (col4 <= w3)) begin
      zone = ZONE_CENTER;
    end else begin
      zone = ZONE_RIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    do_latch   = 1'b0;
    do_mul     = 1'b0;
    do_cmp     = 1'b0;
    div_start  = 1'b0;
    load       = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          do_latch   = 1'b1;
          state_next = BK_MUL;
        end
      end
      BK_MUL: begin
        do_mul     = 1'b1;
        state_next = BK_CMP;
      end
      BK_CMP: begin
        do_cmp = 1'b1;
        if (found_now) begin
          div_start  = 1'b1;
          state_next = BK_DIV;
        end else begin
          state_next = BK_DONE;
        end
      end
      BK_DIV: begin
        if (!row_busy && !col_busy) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (!out_valid || out_ready) begin
          load       = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_latch) begin
      cnt  <= rec_cnt;
      rsum <= rec_rsum;
      csum <= rec_csum;
      w    <= rec_w;
      h    <= rec_h;
    end
    if (do_mul) begin
      area   <= AW'((2*SW)'(w) * (2*SW)'(h));
      cnt400 <= (AW'(cnt) << 8) + (AW'(cnt) << 7) + (AW'(cnt) << 4);
    end
    if (do_cmp) begin
      found <= found_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.found        <= found;
      out_data.centroid_row <= found ? CENT_W'(q_row) : '0;
      out_data.centroid_col <= found ? CENT_W'(q_col) : '0;
      out_data.zone         <= zone;
      out_data.match_count  <= COUNT_W'(cnt);
    end
  end

  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.found) |->
      (out_data.zone == ZONE_NONE) && (out_data.centroid_row == '0) &&
      (out_data.centroid_col == '0))
    else $error("result without a blob carries a centroid or zone");

  a_found_zone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.found) |-> (out_data.zone != ZONE_NONE))
    else $error("found blob without a zone");

  a_div_only_found: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == BK_DIV) && found && row_busy && col_busy)
    else $error("divider started without a found blob");

endmodule

`default_nettype wire

// ===== sv/color_blob_centroid_zone_top.sv =====
// HSV color blob detector: pixels in, per-frame count, centroid and zone out.
// Pixels are taken one per clock with no gaps needed; the front end matches and
// accumulates in the same cycle. At a frame's last pixel its totals enter a
// two-entry queue; the back end then does the found test (one multiply stage,
// one compare) and, for a found blob, the two centroid divisions, which run
// side by side on one-bit-per-cycle restoring dividers. The input
// stalls only when two finished frames are still waiting in the queue, which
// happens only for frames shorter than the back end's per-frame time or when the
// result is not taken. Config writes are taken every cycle and should happen
// between frames; the frame size in force at each pixel decides row and frame ends.
// depends on cbcz_pkg, cbcz_front, cbcz_fifo, cbcz_div, cbcz_back
`default_nettype none

module color_blob_centroid_zone_top import cbcz_pkg::*; #(
  parameter int MAX_SIDE = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire pixel_t            in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output result_t                out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [SIDE_W-1:0] cfg_data
);

  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int CW   = $clog2(MAX_SIDE);
  localparam int NW   = $clog2(MAX_SIDE * MAX_SIDE + 1);
  localparam int SUMW = NW + CW;
  localparam int RW   = NW + 2 * SUMW + 2 * SW;

  cfg_t            cfg;
  logic            q_full;
  logic            q_empty;
  logic            push;
  logic            pop;
  logic [NW-1:0]   f_cnt;
  logic [SUMW-1:0] f_rsum;
  logic [SUMW-1:0] f_csum;
  logic [SW-1:0]   f_w;
  logic [SW-1:0]   f_h;
  logic [RW-1:0]   q_in;
  logic [RW-1:0]   q_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HUE_MIN:      cfg.hue_min      <= cfg_data[CH_W-1:0];
        CFG_HUE_MAX:      cfg.hue_max      <= cfg_data[CH_W-1:0];
        CFG_SAT_MIN:      cfg.sat_min      <= cfg_data[CH_W-1:0];
        CFG_SAT_MAX:      cfg.sat_max      <= cfg_data[CH_W-1:0];
        CFG_VAL_MIN:      cfg.val_min      <= cfg_data[CH_W-1:0];
        CFG_VAL_MAX:      cfg.val_max      <= cfg_data[CH_W-1:0];
        CFG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: cfg.frame_height <= cfg_data;
      endcase
    end
  end

  cbcz_front #(.MAX_SIDE(MAX_SIDE)) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .push     (push),
    .rsum_out (f_rsum),
    .csum_out (f_csum),
    .cnt_out  (f_cnt),
    .w_out    (f_w),
    .h_out    (f_h)
  );

  assign q_in = {f_cnt, f_rsum, f_csum, f_w, f_h};

  cbcz_fifo #(.W(RW), .DEPTH(2)) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (q_in),
    .pop       (pop),
    .pop_data  (q_out),
    .full      (q_full),
    .empty     (q_empty)
  );

  cbcz_back #(.MAX_SIDE(MAX_SIDE)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .pop       (pop),
    .rec       (q_out),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== verif/cbcz_frame_check.sv =====
// port-level checker for the color blob centroid zone block
// tracks config writes and pixels, predicts each frame result and compares it
// depends on cbcz_pkg
module cbcz_frame_check import cbcz_pkg::*; #(
  parameter int MAX_SIDE = 1024
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire pixel_t            in_data,
  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire result_t           out_data,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [SIDE_W-1:0] cfg_data,
  output int                     fail_count,
  output int                     frames_due
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t            regs;
  int unsigned     row_pos;
  int unsigned     col_pos;
  int unsigned     hits;
  longint unsigned row_total;
  longint unsigned col_total;
  int              frame_no = 0;
  int              fails = 0;
  result_t         pending_frames[$];

  assign fail_count = fails;

  function automatic int unsigned clamp_side(logic [SIDE_W-1:0] v);
    if (v == '0) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return v;
  endfunction

  task automatic report(string msg);
    $display("[%0t] frame %0d: %s", $time, frame_no, msg);
    fails++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  // totals of the frame just closed, turned into found, centroid and zone
  function automatic result_t frame_summary(int unsigned w, int unsigned h);
    result_t         r;
    longint unsigned cr;
    longint unsigned cc;
    r = '0;
    r.zone = ZONE_NONE;
    r.match_count = COUNT_W'(hits);
    // exactly 0.25 percent is not found
    if (longint'(hits) * 400 > longint'(w) * longint'(h)) begin
      cr = row_total / hits;
      cc = col_total / hits;
      r.found = 1'b1;
      r.centroid_row = CENT_W'(cr);
      r.centroid_col = CENT_W'(cc);
      if (cc > 0 && cc * 4 < w) r.zone = ZONE_LEFT;
      else if (cc * 4 >= w && cc * 4 <= 3 * w) r.zone = ZONE_CENTER;
      else r.zone = ZONE_RIGHT;
    end
    return r;
  endfunction

  task automatic apply_write(logic [IDX_W-1:0] idx, logic [SIDE_W-1:0] data);
    case (idx)
      CFG_HUE_MIN:      regs.hue_min = data[CH_W-1:0];
      CFG_HUE_MAX:      regs.hue_max = data[CH_W-1:0];
      CFG_SAT_MIN:      regs.sat_min = data[CH_W-1:0];
      CFG_SAT_MAX:      regs.sat_max = data[CH_W-1:0];
      CFG_VAL_MIN:      regs.val_min = data[CH_W-1:0];
      CFG_VAL_MAX:      regs.val_max = data[CH_W-1:0];
      CFG_FRAME_WIDTH:  regs.frame_width = data;
      CFG_FRAME_HEIGHT: regs.frame_height = data;
      default: ;
    endcase
  endtask

  task automatic take_pixel(pixel_t p);
    int unsigned w;
    int unsigned h;
    w = clamp_side(regs.frame_width);
    h = clamp_side(regs.frame_height);
    if (p.hue != 0 && p.hue >= regs.hue_min && p.hue <= regs.hue_max &&
        p.sat >= regs.sat_min && p.sat <= regs.sat_max &&
        p.val >= regs.val_min && p.val <= regs.val_max) begin
      hits++;
      row_total += row_pos;
      col_total += col_pos;
    end
    // sizes in force at this pixel decide the row and frame ends
    if (col_pos + 1 < w) begin
      col_pos++;
    end else begin
      col_pos = 0;
      if (row_pos + 1 < h) begin
        row_pos++;
      end else begin
        pending_frames.push_back(frame_summary(w, h));
        row_pos = 0;
        hits = 0;
        row_total = 0;
        col_total = 0;
      end
    end
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (pending_frames.size() == 0) begin
      report("result item with no frame outstanding");
      return;
    end
    want = pending_frames.pop_front();
    check_field("found", got.found, want.found);
    check_field("centroid_row", got.centroid_row, want.centroid_row);
    check_field("centroid_col", got.centroid_col, want.centroid_col);
    check_field("zone", got.zone, want.zone);
    check_field("match_count", got.match_count, want.match_count);
    frame_no++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs = CFG_RESET;
      row_pos = 0;
      col_pos = 0;
      hits = 0;
      row_total = 0;
      col_total = 0;
      pending_frames.delete();
    end else begin
      // results first so an item taken at this edge cannot match itself
      if (out_valid && out_ready) check_result(out_data);
      // a pixel taken at the same edge as a write still sees the old registers
      if (in_valid && in_ready) take_pixel(in_data);
      if (cfg_valid && cfg_ready) apply_write(cfg_index, cfg_data);
    end
    frames_due = pending_frames.size();
  end

endmodule

// ===== verif/tb_color_blob_centroid_zone_top.sv =====
// testbench top for the color blob centroid zone block
// drives pixels, config writes and result backpressure; cbcz_frame_check does the checking
// depends on cbcz_pkg, cbcz_frame_check and the block's RTL
module tb_color_blob_centroid_zone_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cbcz_pkg::*;

  localparam int MAX_SIDE     = 1024;
  localparam int LIMIT        = 1_000_000;
  localparam int SETTLE       = 40;
  localparam int HOLD_OFF     = 400;
  localparam int RANDOM_ITEMS = 960;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  pixel_t            in_data = '0;
  logic              in_ready;
  logic              out_valid;
  logic              out_ready = 1'b0;
  result_t           out_data;
  logic              cfg_valid = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [SIDE_W-1:0] cfg_data = '0;
  logic              cfg_ready;

  int     fails;
  int     due;
  int     cycles = 0;
  int     hold_req = 0;
  bit     tx_busy = 1'b0;
  int     hit_pct = 50;
  cfg_t   shadow = CFG_RESET;

  // 3x3 frame at reset thresholds: both corners of the box and one step outside each
  pixel_t edge_pix [9] = '{
    {8'd120, 8'd0,   8'd150}, {8'd130, 8'd150, 8'd200}, {8'd119, 8'd75,  8'd175},
    {8'd131, 8'd75,  8'd175}, {8'd125, 8'd151, 8'd175}, {8'd125, 8'd75,  8'd149},
    {8'd125, 8'd75,  8'd201}, {8'd0,   8'd0,   8'd0},   {8'hff,  8'hff,  8'hff}
  };

  color_blob_centroid_zone_top #(.MAX_SIDE(MAX_SIDE)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cbcz_frame_check #(.MAX_SIDE(MAX_SIDE)) u_frame_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fails), .frames_due(due)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_pixel(pixel_t p);
    int gap;
    gap = tx_busy ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(logic [IDX_W-1:0] idx, logic [SIDE_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_config(cfg_t c);
    write_reg(CFG_HUE_MIN, SIDE_W'(c.hue_min));
    write_reg(CFG_HUE_MAX, SIDE_W'(c.hue_max));
    write_reg(CFG_SAT_MIN, SIDE_W'(c.sat_min));
    write_reg(CFG_SAT_MAX, SIDE_W'(c.sat_max));
    write_reg(CFG_VAL_MIN, SIDE_W'(c.val_min));
    write_reg(CFG_VAL_MAX, SIDE_W'(c.val_max));
    write_reg(CFG_FRAME_WIDTH, c.frame_width);
    write_reg(CFG_FRAME_HEIGHT, c.frame_height);
    cfg_valid <= 1'b0;
    shadow = c;
  endtask

  // stop offering pixels, wait for every frame result, then let the back end drain
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic cfg_t full_range(logic [SIDE_W-1:0] w, logic [SIDE_W-1:0] h);
    cfg_t c;
    c = '{hue_min: 8'd0, hue_max: 8'hff, sat_min: 8'd0, sat_max: 8'hff,
          val_min: 8'd0, val_max: 8'hff, frame_width: w, frame_height: h};
    return c;
  endfunction

  function automatic logic [7:0] edge_val(logic [7:0] lo, logic [7:0] hi);
    case ($urandom_range(0, 7))
      0: return lo;
      1: return hi;
      2: return lo - 8'd1;
      3: return hi + 8'd1;
      4: return 8'd0;
      5: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] in_span(logic [7:0] lo, logic [7:0] hi);
    return (lo <= hi) ? 8'($urandom_range(lo, hi)) : 8'($urandom);
  endfunction

  function automatic pixel_t pick_pixel(bit hit);
    pixel_t p;
    if (hit) begin
      p.hue = in_span((shadow.hue_min == 0) ? 8'd1 : shadow.hue_min, shadow.hue_max);
      p.sat = in_span(shadow.sat_min, shadow.sat_max);
      p.val = in_span(shadow.val_min, shadow.val_max);
    end else begin
      p.hue = edge_val(shadow.hue_min, shadow.hue_max);
      p.sat = edge_val(shadow.sat_min, shadow.sat_max);
      p.val = edge_val(shadow.val_min, shadow.val_max);
    end
    return p;
  endfunction

  task automatic random_span(output logic [7:0] lo, output logic [7:0] hi);
    logic [7:0] a;
    logic [7:0] b;
    a = 8'($urandom);
    b = 8'($urandom);
    case ($urandom_range(0, 9))
      0: begin lo = 8'd0; hi = 8'hff; end
      1: begin lo = (a > b) ? a : b; hi = (a > b) ? b : a; end  // empty range
      2: begin lo = a; hi = a; end
      default: begin lo = (a < b) ? a : b; hi = (a < b) ? b : a; end
    endcase
  endtask

  function automatic logic [SIDE_W-1:0] small_side(int unsigned top_v);
    return ($urandom_range(0, 9) == 0) ? '0 : SIDE_W'($urandom_range(1, top_v));
  endfunction

  // result side: random stalls, busy stretches, and one long hold-off on request
  initial begin : sink
    int gap;
    int seen;
    bit rx_busy;
    seen = 0;
    rx_busy = 1'b0;
    forever begin
      if ($urandom_range(0, 19) == 0) rx_busy = !rx_busy;
      gap = rx_busy ? 0 : $urandom_range(0, 14);
      if (hold_req != seen) begin
        seen = hold_req;
        gap = HOLD_OFF;
      end
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  initial begin : stim
    cfg_t c;
    int   n;
    int   sent;
    int   phase;
    int   area;
    int   p1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset thresholds kept, only the size written
    write_reg(CFG_FRAME_WIDTH, 11'd3);
    write_reg(CFG_FRAME_HEIGHT, 11'd3);
    cfg_valid <= 1'b0;
    shadow.frame_width = 11'd3;
    shadow.frame_height = 11'd3;
    foreach (edge_pix[i]) send_pixel(edge_pix[i]);

    // zero width means one pixel per frame; a zero hue never matches
    settle();
    set_config(full_range(11'd0, 11'd1));
    send_pixel({8'd0, 8'd100, 8'd100});
    send_pixel({8'hff, 8'hff, 8'hff});
    send_pixel({8'd1, 8'd0, 8'd0});

    // min above max matches nothing
    settle();
    c = full_range(11'd2, 11'd2);
    c.hue_min = 8'd200;
    c.hue_max = 8'd100;
    set_config(c);
    send_pixel({8'd150, 8'd0, 8'd0});
    send_pixel({8'd200, 8'd10, 8'd10});
    send_pixel({8'd100, 8'd20, 8'd20});
    send_pixel({8'hff, 8'hff, 8'hff});

    // single match at column 0, 1, 2 of a 5-wide row: right, left, center
    settle();
    set_config(full_range(11'd5, 11'd1));
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 5; i++) begin
        send_pixel((i == k) ? pixel_t'({8'd200, 8'd200, 8'd200}) :
                              pixel_t'({8'd0, 8'd200, 8'd200}));
      end
    end

    // 20x20 frame with one match, exactly 0.25 percent
    settle();
    set_config(full_range(11'd20, 11'd20));
    p1 = $urandom_range(0, 399);
    for (int i = 0; i < 400; i++) begin
      if (i == p1) send_pixel(pick_pixel(1'b1));
      else send_pixel({8'd0, 8'($urandom), 8'($urandom)});
    end

    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      settle();
      tx_busy = ($urandom_range(0, 3) == 0);
      case (phase)
        0: begin
          // one-pixel frames at full rate while the result side holds off
          set_config(full_range(11'd1, 11'd1));
          tx_busy = 1'b1;
          hold_req++;
          repeat (60) send_pixel(pick_pixel($urandom_range(0, 1)));
        end
        default: begin
          random_span(c.hue_min, c.hue_max);
          random_span(c.sat_min, c.sat_max);
          random_span(c.val_min, c.val_max);
          c.frame_width = small_side(12);
          c.frame_height = small_side(6);
          set_config(c);
          hit_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 100);
          area = ((c.frame_width == 0) ? 1 : c.frame_width) *
                 ((c.frame_height == 0) ? 1 : c.frame_height);
          n = $urandom_range(1, 4) * area;
          // sometimes stop mid-frame so the next sizes apply to a partial frame
          if ($urandom_range(0, 3) == 0) n += $urandom_range(0, area - 1);
          repeat (n) send_pixel(pick_pixel($urandom_range(1, 100) <= hit_pct));
          sent += n;
        end
      endcase
      phase++;
    end

    settle();
    if (fails == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
